FILE: rtl/i2cms_pkg.sv
// Shared types and constants for the I2C master byte sequencer.
// No dependencies; used by i2cms_core and i2c_master_byte_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

   // Command codes carried in the func field.
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_STOP  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   // Reset value of the acknowledge retry limit register.
   localparam logic [7:0] ACK_RETRY_RESET = 8'd100;

   // Most significant bit of a byte, sent first on the bus.
   localparam int unsigned MSB = 7;

   // Number of bits in a byte on the bus.
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // One input item: a bus tick with an optional command.
   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] func;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       sda_in;
   } item_type;

   // One result item: line drives and status after the tick.
   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_ok;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/i2c_master_byte_sequencer.sv
// Top level of the I2C master byte sequencer: input register, core, result register.
// Depends on i2cms_pkg and i2cms_core.
`timescale 1ns / 1ps
`default_nettype none

// Each input item on the req_ channel is one bus delay tick: the sampled SDA
// level and, optionally, a command (start, stop, write byte, read byte) that is
// taken only while the sequencer is idle. Every item produces exactly one
// result item on the rsp_ channel with the SCL and SDA pull-down drives and the
// busy, done, received byte and acknowledge status after that tick.
// An item is taken into an input register, the sequencer advances one phase as
// it moves into the result register, and the result is offered from there.
// One item per cycle is sustained while rsp_stall is low: the single phase
// update sits between the two registers. When rsp_stall is high the result
// register holds, one further item waits in the input register and then
// req_stall rises.
// The csr_ channel writes the acknowledge retry limit; csr_ready is always high
// and writes are expected only while the sequencer is idle.
// Reset clears both registers, returns the sequencer to idle with both lines
// released and sets the retry limit to 100.
module i2c_master_byte_sequencer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic       req_cmd_valid,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_tx_byte,
   input  wire logic       req_ack_to_send,
   input  wire logic       req_sda_in,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_scl_drive_low,
   output      logic       rsp_sda_drive_low,
   output      logic       rsp_busy_res,
   output      logic       rsp_done_res,
   output      logic [7:0] rsp_rx_byte,
   output      logic       rsp_ack_ok,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [7:0] csr_ack_retry_limit
);

   logic                  in_valid_ff, in_valid_in;
   i2cms_pkg::item_type   item_ff;
   logic                  out_valid_ff, out_valid_in;
   i2cms_pkg::result_type result_ff;
   i2cms_pkg::result_type result_next;
   logic [7:0]            limit_ff;
   logic                  advance;
   logic                  req_take;

   // Handshake: the core steps when the input register moves into a free result slot.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Input and result registers, plus the retry limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= i2cms_pkg::ACK_RETRY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_ack_retry_limit;
         end
      end
      if (req_take) begin
         item_ff.cmd_valid   <= req_cmd_valid;
         item_ff.func        <= req_func;
         item_ff.tx_byte     <= req_tx_byte;
         item_ff.ack_to_send <= req_ack_to_send;
         item_ff.sda_in      <= req_sda_in;
      end
      if (advance) begin
         result_ff <= result_next;
      end
   end

   i2cms_core u_core (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .item            (item_ff),
      .ack_retry_limit (limit_ff),
      .result          (result_next)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_scl_drive_low = result_ff.scl_drive_low;
   assign rsp_sda_drive_low = result_ff.sda_drive_low;
   assign rsp_busy_res      = result_ff.busy_res;
   assign rsp_done_res      = result_ff.done_res;
   assign rsp_rx_byte       = result_ff.rx_byte;
   assign rsp_ack_ok        = result_ff.ack_ok;

`ifndef SYNTHESIS
   // A completing tick never reports the sequencer as still busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while busy");

   // Every core step leaves a result waiting in the result register.
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("core step without a result");

   // The input side is only held off while an item waits in the input register.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

FILE: rtl/i2cms_core.sv
// Tick sequencer of the I2C master: phase state machine and data registers.
// Depends on i2cms_pkg for the item, result and command definitions.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire i2cms_pkg::item_type    item,
   input  wire logic [7:0]             ack_retry_limit,
   output      i2cms_pkg::result_type  result
);

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_START2  = 4'd1,
      PH_STOP2   = 4'd2,
      PH_STOP3   = 4'd3,
      PH_W_HIGH  = 4'd4,
      PH_W_LOW   = 4'd5,
      PH_W_SETUP = 4'd6,
      PH_W_ACK   = 4'd7,
      PH_W_POLL  = 4'd8,
      PH_R_HIGH  = 4'd9,
      PH_R_SAMP  = 4'd10,
      PH_R_AHIGH = 4'd11,
      PH_R_ALOW  = 4'd12
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] retry_ff, retry_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       scl_low_ff, scl_low_in;
   logic       sda_low_ff, sda_low_in;
   logic       ack_status_ff, ack_status_in;
   logic [7:0] rx_hold_ff, rx_hold_in;
   logic       done;
   logic [3:0] bit_count_inc;
   logic [8:0] retry_inc;

   assign bit_count_inc = bit_count_ff + 4'd1;
   assign retry_inc     = {1'b0, retry_ff} + 9'd1;

   // Next state for one tick.
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      retry_in      = retry_ff;
      ack_choice_in = ack_choice_ff;
      scl_low_in    = scl_low_ff;
      sda_low_in    = sda_low_ff;
      ack_status_in = ack_status_ff;
      rx_hold_in    = rx_hold_ff;
      done          = 1'b0;
      case (phase_ff)
         PH_START2: begin
            scl_low_in = 1'b1;
            phase_in   = PH_IDLE;
            done       = 1'b1;
         end
         PH_STOP2: begin
            scl_low_in = 1'b0;
            phase_in   = PH_STOP3;
         end
         PH_STOP3: begin
            sda_low_in = 1'b0;
            phase_in   = PH_IDLE;
            done       = 1'b1;
         end
         PH_W_HIGH: begin
            scl_low_in = 1'b0;
            phase_in   = PH_W_LOW;
         end
         PH_W_LOW: begin
            scl_low_in   = 1'b1;
            shift_in     = {shift_ff[6:0], 1'b0};
            bit_count_in = bit_count_inc;
            phase_in     = (bit_count_inc >= i2cms_pkg::BITS_PER_BYTE) ? PH_W_ACK
                                                                      : PH_W_SETUP;
         end
         PH_W_SETUP: begin
            sda_low_in = ~shift_ff[i2cms_pkg::MSB];
            phase_in   = PH_W_HIGH;
         end
         PH_W_ACK: begin
            sda_low_in = 1'b0;
            scl_low_in = 1'b0;
            retry_in   = 8'd0;
            phase_in   = PH_W_POLL;
         end
         PH_W_POLL: begin
            // Low SDA is an acknowledge; enough high samples in a row is a NACK.
            if (!item.sda_in) begin
               ack_status_in = 1'b1;
               scl_low_in    = 1'b1;
               phase_in      = PH_IDLE;
               done          = 1'b1;
            end else if (retry_inc >= {1'b0, ack_retry_limit}) begin
               ack_status_in = 1'b0;
               scl_low_in    = 1'b1;
               phase_in      = PH_IDLE;
               done          = 1'b1;
            end else begin
               retry_in = retry_inc[7:0];
            end
         end
         PH_R_HIGH: begin
            scl_low_in = 1'b0;
            phase_in   = PH_R_SAMP;
         end
         PH_R_SAMP: begin
            shift_in     = {shift_ff[6:0], item.sda_in};
            bit_count_in = bit_count_inc;
            scl_low_in   = 1'b1;
            if (bit_count_inc >= i2cms_pkg::BITS_PER_BYTE) begin
               sda_low_in = ack_choice_ff;
               phase_in   = PH_R_AHIGH;
            end else begin
               phase_in = PH_R_HIGH;
            end
         end
         PH_R_AHIGH: begin
            scl_low_in = 1'b0;
            phase_in   = PH_R_ALOW;
         end
         PH_R_ALOW: begin
            scl_low_in = 1'b1;
            rx_hold_in = shift_ff;
            phase_in   = PH_IDLE;
            done       = 1'b1;
         end
         default: begin
            // Idle, and any unused code: take a command if one is offered.
            phase_in = PH_IDLE;
            if (item.cmd_valid) begin
               bit_count_in = 4'd0;
               retry_in     = 8'd0;
               case (item.func)
                  i2cms_pkg::FUNC_START: begin
                     sda_low_in = 1'b1;
                     phase_in   = PH_START2;
                  end
                  i2cms_pkg::FUNC_STOP: begin
                     sda_low_in = 1'b1;
                     phase_in   = PH_STOP2;
                  end
                  i2cms_pkg::FUNC_WRITE: begin
                     shift_in   = item.tx_byte;
                     scl_low_in = 1'b1;
                     sda_low_in = ~item.tx_byte[i2cms_pkg::MSB];
                     phase_in   = PH_W_HIGH;
                  end
                  default: begin
                     ack_choice_in = item.ack_to_send;
                     shift_in      = 8'd0;
                     scl_low_in    = 1'b1;
                     sda_low_in    = 1'b0;
                     phase_in      = PH_R_HIGH;
                  end
               endcase
            end
         end
      endcase
   end

   // State registers advance once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         retry_ff      <= 8'd0;
         ack_choice_ff <= 1'b0;
         scl_low_ff    <= 1'b0;
         sda_low_ff    <= 1'b0;
         ack_status_ff <= 1'b0;
         rx_hold_ff    <= 8'd0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         retry_ff      <= retry_in;
         ack_choice_ff <= ack_choice_in;
         scl_low_ff    <= scl_low_in;
         sda_low_ff    <= sda_low_in;
         ack_status_ff <= ack_status_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

   // Result of this tick, taken from the next state.
   always_comb begin
      result.scl_drive_low = scl_low_in;
      result.sda_drive_low = sda_low_in;
      result.busy_res      = (phase_in != PH_IDLE);
      result.done_res      = done;
      result.rx_byte       = rx_hold_in;
      result.ack_ok        = ack_status_in;
   end

endmodule

`default_nettype wire

FILE: test/i2c_master_byte_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_byte_sequencer: bus ticks and commands go in on
// the req_ channel and every result item is checked against a tick-accurate prediction.
// Depends on i2cms_pkg and the RTL of i2c_master_byte_sequencer.

module i2c_master_byte_sequencer_tb;

   // Line phases of the sequencer, one per tick.
   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_START_END, SEQ_STOP_RISE, SEQ_STOP_END,
      SEQ_WR_HIGH, SEQ_WR_LOW, SEQ_WR_SETUP, SEQ_WR_ACK, SEQ_WR_POLL,
      SEQ_RD_HIGH, SEQ_RD_SAMPLE, SEQ_RD_ACK_HIGH, SEQ_RD_ACK_LOW
   } seq_phase_type;

   // Which side of the handshake idles at random.
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // More high samples than any retry limit tolerates, so the write ends in a NACK.
   localparam int NACK_POLLS = 256;
   // Ticks of a write between the command and the first acknowledge poll:
   // two for the first bit, three for each of the other seven, one to release the lines.
   localparam int WRITE_BIT_TICKS = 24;
   // Enough command-free ticks with SDA low to bring any command to its end.
   localparam int DRAIN_TICKS = 30;
   localparam int HOLD_CYCLES = 64;
   localparam int PHASE_TICKS = 220;
   localparam int PRINT_LIMIT = 200;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_cmd_valid = 1'b0;
   logic [1:0] req_func = i2cms_pkg::FUNC_START;
   logic [7:0] req_tx_byte = 8'h00;
   logic       req_ack_to_send = 1'b0;
   logic       req_sda_in = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl_drive_low;
   logic       rsp_sda_drive_low;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_rx_byte;
   logic       rsp_ack_ok;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_ack_retry_limit = i2cms_pkg::ACK_RETRY_RESET;

   // Ticks waiting to be offered and line states waiting to be seen.
   i2cms_pkg::item_type   tick_q[$];
   i2cms_pkg::result_type expected_lines_q[$];

   idle_mode_type idle_mode = IDLE_NONE;
   int         noise_pct = 0;
   int         mismatch_count = 0;
   int         ticks_queued = 0;
   logic       hold_armed = 1'b0;
   logic       hold_used = 1'b0;
   int         hold_left = 0;

   // Predicted sequencer state, starting from its reset values.
   seq_phase_type seq_phase = SEQ_IDLE;
   logic [3:0] bits_done = 4'd0;
   logic [7:0] shifter = 8'h00;
   logic [7:0] polls = 8'h00;
   logic       ack_pick = 1'b0;
   logic       scl_low = 1'b0;
   logic       sda_low = 1'b0;
   logic       acked = 1'b0;
   logic [7:0] rx_last = 8'h00;
   logic [7:0] ack_limit = i2cms_pkg::ACK_RETRY_RESET;

   always #1 clock = ~clock;

   i2c_master_byte_sequencer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd_valid       (req_cmd_valid),
      .req_func            (req_func),
      .req_tx_byte         (req_tx_byte),
      .req_ack_to_send     (req_ack_to_send),
      .req_sda_in          (req_sda_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_scl_drive_low   (rsp_scl_drive_low),
      .rsp_sda_drive_low   (rsp_sda_drive_low),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_done_res        (rsp_done_res),
      .rsp_rx_byte         (rsp_rx_byte),
      .rsp_ack_ok          (rsp_ack_ok),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_ack_retry_limit (csr_ack_retry_limit)
   );

   // Advance the predicted sequencer by one tick and give the line state after it.
   task automatic step_sequencer(input i2cms_pkg::item_type t,
                                 output i2cms_pkg::result_type r);
      logic       finished;
      logic [8:0] next_polls;
      finished = 1'b0;
      next_polls = 9'd0;
      case (seq_phase)
         SEQ_START_END: begin
            scl_low = 1'b1;
            seq_phase = SEQ_IDLE;
            finished = 1'b1;
         end
         SEQ_STOP_RISE: begin
            scl_low = 1'b0;
            seq_phase = SEQ_STOP_END;
         end
         SEQ_STOP_END: begin
            sda_low = 1'b0;
            seq_phase = SEQ_IDLE;
            finished = 1'b1;
         end
         SEQ_WR_HIGH: begin
            scl_low = 1'b0;
            seq_phase = SEQ_WR_LOW;
         end
         SEQ_WR_LOW: begin
            scl_low = 1'b1;
            shifter = shifter << 1;
            bits_done = bits_done + 4'd1;
            seq_phase = (bits_done >= i2cms_pkg::BITS_PER_BYTE) ? SEQ_WR_ACK : SEQ_WR_SETUP;
         end
         SEQ_WR_SETUP: begin
            sda_low = ~shifter[i2cms_pkg::MSB];
            seq_phase = SEQ_WR_HIGH;
         end
         SEQ_WR_ACK: begin
            sda_low = 1'b0;
            scl_low = 1'b0;
            polls = 8'h00;
            seq_phase = SEQ_WR_POLL;
         end
         SEQ_WR_POLL: begin
            // A low sample acknowledges; the limit-th high sample in a row gives up.
            // A limit of zero gives up on the first high sample.
            next_polls = {1'b0, polls} + 9'd1;
            if (!t.sda_in || next_polls >= {1'b0, ack_limit}) begin
               acked = ~t.sda_in;
               scl_low = 1'b1;
               seq_phase = SEQ_IDLE;
               finished = 1'b1;
            end else begin
               polls = next_polls[7:0];
            end
         end
         SEQ_RD_HIGH: begin
            scl_low = 1'b0;
            seq_phase = SEQ_RD_SAMPLE;
         end
         SEQ_RD_SAMPLE: begin
            shifter = {shifter[6:0], t.sda_in};
            bits_done = bits_done + 4'd1;
            scl_low = 1'b1;
            if (bits_done >= i2cms_pkg::BITS_PER_BYTE) begin
               sda_low = ack_pick;
               seq_phase = SEQ_RD_ACK_HIGH;
            end else begin
               seq_phase = SEQ_RD_HIGH;
            end
         end
         SEQ_RD_ACK_HIGH: begin
            scl_low = 1'b0;
            seq_phase = SEQ_RD_ACK_LOW;
         end
         SEQ_RD_ACK_LOW: begin
            scl_low = 1'b1;
            rx_last = shifter;
            seq_phase = SEQ_IDLE;
            finished = 1'b1;
         end
         default: begin
            // Idle: a command is taken, otherwise the lines and status are held.
            seq_phase = SEQ_IDLE;
            if (t.cmd_valid) begin
               bits_done = 4'd0;
               polls = 8'h00;
               case (t.func)
                  i2cms_pkg::FUNC_START: begin
                     sda_low = 1'b1;
                     seq_phase = SEQ_START_END;
                  end
                  i2cms_pkg::FUNC_STOP: begin
                     sda_low = 1'b1;
                     seq_phase = SEQ_STOP_RISE;
                  end
                  i2cms_pkg::FUNC_WRITE: begin
                     shifter = t.tx_byte;
                     scl_low = 1'b1;
                     sda_low = ~t.tx_byte[i2cms_pkg::MSB];
                     seq_phase = SEQ_WR_HIGH;
                  end
                  default: begin
                     ack_pick = t.ack_to_send;
                     shifter = 8'h00;
                     scl_low = 1'b1;
                     sda_low = 1'b0;
                     seq_phase = SEQ_RD_HIGH;
                  end
               endcase
            end
         end
      endcase
      r.scl_drive_low = scl_low;
      r.sda_drive_low = sda_low;
      r.busy_res = (seq_phase != SEQ_IDLE);
      r.done_res = finished;
      r.rx_byte = rx_last;
      r.ack_ok = acked;
   endtask

   function automatic bit rbit();
      return 1'($urandom_range(1));
   endfunction

   // Chance in a hundred that the given side idles on this cycle.
   function automatic int idle_pct(bit receiver);
      case (idle_mode)
         IDLE_SENDER:   return receiver ? 0 : 83;
         IDLE_RECEIVER: return receiver ? 83 : 0;
         IDLE_BOTH:     return 34;
         default:       return 0;
      endcase
   endfunction

   task automatic note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic push_tick(bit cmd, logic [1:0] func, logic [7:0] tx, bit ack, bit sda);
      i2cms_pkg::item_type t;
      t.cmd_valid = cmd;
      t.func = func;
      t.tx_byte = tx;
      t.ack_to_send = ack;
      t.sda_in = sda;
      tick_q.push_back(t);
      ticks_queued++;
   endtask

   // A tick whose command fields are random; they only matter if cmd is set.
   task automatic push_filler(bit cmd, bit sda);
      push_tick(cmd, 2'($urandom_range(3)), 8'($urandom_range(255)), rbit(), sda);
   endtask

   // A tick while a command runs: now and then a command is offered, which must be ignored.
   task automatic push_busy(bit sda);
      push_filler(int'($urandom_range(99)) < noise_pct, sda);
   endtask

   // Queue one whole command from idle with the SDA levels a slave would give.
   // For a write, highs is the number of high samples before the acknowledge.
   // For a read, data is the byte the slave returns.
   task automatic issue(logic [1:0] func, logic [7:0] data, bit ack, int highs);
      int limit;
      limit = (ack_limit == 8'd0) ? 1 : int'(ack_limit);
      push_tick(1'b1, func, data, ack, rbit());
      case (func)
         i2cms_pkg::FUNC_START: push_busy(rbit());
         i2cms_pkg::FUNC_STOP:  repeat (2) push_busy(rbit());
         i2cms_pkg::FUNC_WRITE: begin
            repeat (WRITE_BIT_TICKS) push_busy(rbit());
            if (highs >= limit) begin
               repeat (limit) push_busy(1'b1);
            end else begin
               repeat (highs) push_busy(1'b1);
               push_busy(1'b0);
            end
         end
         default: begin
            for (int i = 7; i >= 0; i--) begin
               push_busy(rbit());
               push_busy(data[i]);
            end
            repeat (2) push_busy(rbit());
         end
      endcase
   endtask

   // Mostly well-formed commands with random content and gaps, some broken runs.
   task automatic random_traffic(int count);
      int stop_at;
      int pick;
      int highs;
      stop_at = ticks_queued + count;
      while (ticks_queued < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // Random ticks land anywhere in a command; SDA then stays low until all settles.
            repeat ($urandom_range(1, 12)) push_filler(rbit(), rbit());
            repeat (DRAIN_TICKS) push_filler(1'b0, 1'b0);
         end else begin
            repeat ($urandom_range(3)) push_filler(1'b0, rbit());
            pick = $urandom_range(99);
            highs = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 12) : NACK_POLLS;
            issue(2'($urandom_range(3)), 8'($urandom_range(255)), rbit(), highs);
         end
      end
   endtask

   // Let the sequencer finish, then wait until every item has been answered.
   task automatic settle_and_wait();
      repeat (DRAIN_TICKS) push_filler(1'b0, 1'b0);
      do @(negedge clock);
      while (tick_q.size() != 0 || req_valid || expected_lines_q.size() != 0);
   endtask

   // Register write; only called while the sequencer is idle and nothing is in flight.
   task automatic write_retry_limit(logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_ack_retry_limit <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      ack_limit = value;
      @(negedge clock);
   endtask

   task automatic run_phase(idle_mode_type mode, logic [7:0] limit, bit hold);
      write_retry_limit(limit);
      idle_mode = mode;
      random_traffic(PHASE_TICKS);
      if (hold)
         hold_armed <= 1'b1;
      settle_and_wait();
   endtask

   // Sender: offer queued ticks, predict each one as it is accepted.
   always @(posedge clock) begin : drive_ticks
      i2cms_pkg::item_type   offered;
      i2cms_pkg::item_type   next_tick;
      i2cms_pkg::result_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            offered.cmd_valid = req_cmd_valid;
            offered.func = req_func;
            offered.tx_byte = req_tx_byte;
            offered.ack_to_send = req_ack_to_send;
            offered.sda_in = req_sda_in;
            step_sequencer(offered, predicted);
            expected_lines_q.push_back(predicted);
         end
         if (!req_valid || !req_stall) begin
            if (tick_q.size() != 0 && !(int'($urandom_range(99)) < idle_pct(1'b0))) begin
               next_tick = tick_q.pop_front();
               req_cmd_valid <= next_tick.cmd_valid;
               req_func <= next_tick.func;
               req_tx_byte <= next_tick.tx_byte;
               req_ack_to_send <= next_tick.ack_to_send;
               req_sda_in <= next_tick.sda_in;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // One long receiver hold-off, so that the block fills and stalls its input.
   always @(posedge clock) begin : hold_off
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end
   end

   // Receiver: check each accepted result item against the oldest prediction.
   always @(posedge clock) begin : check_lines
      i2cms_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines_q.size() == 0) begin
               note_mismatch("result item arrived with nothing expected");
            end else begin
               want = expected_lines_q.pop_front();
               compare_field("scl_drive_low", 8'(rsp_scl_drive_low), 8'(want.scl_drive_low));
               compare_field("sda_drive_low", 8'(rsp_sda_drive_low), 8'(want.sda_drive_low));
               compare_field("busy_res", 8'(rsp_busy_res), 8'(want.busy_res));
               compare_field("done_res", 8'(rsp_done_res), 8'(want.done_res));
               compare_field("rx_byte", rsp_rx_byte, want.rx_byte);
               compare_field("ack_ok", 8'(rsp_ack_ok), 8'(want.ack_ok));
            end
         end
         rsp_stall <= (hold_left != 0) || (int'($urandom_range(99)) < idle_pct(1'b1));
      end
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed commands under the reset retry limit.
      // Nothing offered while idle: the released lines are held.
      push_filler(1'b0, 1'b1);
      push_filler(1'b0, 1'b0);
      // Stop with SCL still released: SDA falls while SCL is high.
      issue(i2cms_pkg::FUNC_STOP, 8'($urandom_range(255)), 1'b0, 0);
      issue(i2cms_pkg::FUNC_START, 8'($urandom_range(255)), 1'b1, 0);
      issue(i2cms_pkg::FUNC_WRITE, 8'h00, 1'b0, 0);
      // Commands offered on every busy tick of this write must be ignored.
      noise_pct = 100;
      issue(i2cms_pkg::FUNC_WRITE, 8'hFF, 1'b1, 3);
      noise_pct = 0;
      issue(i2cms_pkg::FUNC_READ, 8'hA5, 1'b1, 0);
      issue(i2cms_pkg::FUNC_READ, 8'h5A, 1'b0, 0);
      // Start with SCL held low from the read.
      issue(i2cms_pkg::FUNC_START, 8'h00, 1'b0, 0);
      // Acknowledge on the last poll before the limit, then a missing acknowledge.
      issue(i2cms_pkg::FUNC_WRITE, 8'h7F, 1'b0, 99);
      issue(i2cms_pkg::FUNC_WRITE, 8'h80, 1'b1, NACK_POLLS);
      issue(i2cms_pkg::FUNC_STOP, 8'hFF, 1'b1, 0);
      settle_and_wait();

      // A zero limit behaves like one: the first high sample is a missing acknowledge.
      write_retry_limit(8'd0);
      issue(i2cms_pkg::FUNC_WRITE, 8'h01, 1'b0, NACK_POLLS);
      issue(i2cms_pkg::FUNC_WRITE, 8'hFE, 1'b1, 0);
      settle_and_wait();

      // Random phases over a range of limits and idling patterns.
      noise_pct = 10;
      run_phase(IDLE_NONE, 8'd255, 1'b1);
      run_phase(IDLE_SENDER, 8'd1, 1'b0);
      run_phase(IDLE_RECEIVER, 8'($urandom_range(2, 20)), 1'b0);
      run_phase(IDLE_BOTH, 8'($urandom_range(21, 254)), 1'b0);
      run_phase(IDLE_NONE, 8'($urandom_range(2, 8)), 1'b0);

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("i2c_master_byte_sequencer_tb: clean");
      else
         $display("i2c_master_byte_sequencer_tb: errors");
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("i2c_master_byte_sequencer_tb: errors");
      $finish;
   end

endmodule
